@@ hw/rtl/imh_pkg.sv @@
// Package for the indexed min-heap: sizes, opcodes and status codes.
// Used by indexed_min_heap and its testbench.
package imh_pkg;
    localparam int CAPACITY  = 256;
    localparam int VERTEX_W  = 8;
    localparam int KEY_W     = 32;
    localparam int SLOT_W    = $clog2(CAPACITY);
    localparam int COUNT_W   = SLOT_W + 1;
    localparam int VERTICES  = 1 << VERTEX_W;
    localparam int LIMIT     = (CAPACITY < VERTICES) ? CAPACITY : VERTICES;
    localparam int HEAP_W    = VERTEX_W + KEY_W;

    localparam logic [1:0] OP_INSERT   = 2'd0;
    localparam logic [1:0] OP_EXTRACT  = 2'd1;
    localparam logic [1:0] OP_DECREASE = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;
    localparam logic [1:0] ST_BAD   = 2'd3;
endpackage

@@ hw/rtl/imh_ram.sv @@
// Generic single-port RAM with registered read.
// No dependencies.
module imh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

@@ hw/rtl/indexed_min_heap.sv @@
// Indexed binary min-heap: insert, extract-min and decrease-key, one command at a time.
// The heap sits in one RAM of (vertex, key) slots. The position map sits in a second RAM;
// its presence bits are flip-flops. Each sift level is a sequence of single-port reads and
// writes. Uses imh_pkg and imh_ram. A result waits in S_DONE until m_ready takes it, and
// no new command is accepted before then. No reset sweep is needed.
module indexed_min_heap
    import imh_pkg::*;
(
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [1:0]                 s_opcode,
    input  logic [VERTEX_W-1:0]        s_vertex,
    input  logic signed [KEY_W-1:0]    s_key,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [VERTEX_W-1:0]        m_out_vertex,
    output logic signed [KEY_W-1:0]    m_out_key,
    output logic [1:0]                 m_status,
    output logic                       m_is_empty,
    output logic [COUNT_W-1:0]         m_entry_total
);
    typedef enum logic [4:0] {
        S_IDLE, S_POS_RD, S_POS_WT, S_DEC_RD, S_DEC_WT, S_DEC_CHK,
        S_UP_RD, S_UP_WT, S_UP_CMP, S_UP_WR_P,
        S_EX_RD, S_EX_WT, S_EX_LAST_RD, S_EX_LAST_WT,
        S_DN_L_RD, S_DN_L_WT, S_DN_R_RD, S_DN_R_WT, S_DN_CMP, S_DN_WR_C,
        S_PLACE, S_DONE
    } state_t;

    state_t                state_reg;
    logic [VERTEX_W-1:0]   vtx_reg;     // moving entry
    logic [KEY_W-1:0]      key_reg;     // biased key of moving entry
    logic [SLOT_W-1:0]     idx_reg;     // current hole
    logic [SLOT_W-1:0]     cidx_reg;    // chosen child / parent slot
    logic [HEAP_W-1:0]     lft_reg;     // chosen child (or parent) entry
    logic [COUNT_W-1:0]    count_reg;
    logic [VERTICES-1:0]   present_reg;
    logic [VERTEX_W-1:0]   ov_reg;
    logic [KEY_W-1:0]      ok_reg;
    logic [1:0]            st_reg;

    // heap RAM
    logic                  h_we;
    logic [SLOT_W-1:0]     h_addr;
    logic [HEAP_W-1:0]     h_wdata, h_rdata;
    // position RAM
    logic                  p_we;
    logic [VERTEX_W-1:0]   p_addr;
    logic [SLOT_W-1:0]     p_wdata, p_rdata;

    imh_ram #(.WIDTH(HEAP_W), .DEPTH(CAPACITY)) u_heap (
        .aclk(aclk), .we(h_we), .addr(h_addr), .wdata(h_wdata), .rdata(h_rdata));
    imh_ram #(.WIDTH(SLOT_W), .DEPTH(VERTICES)) u_pos (
        .aclk(aclk), .we(p_we), .addr(p_addr), .wdata(p_wdata), .rdata(p_rdata));

    localparam logic [KEY_W-1:0] BIAS = {1'b1, {(KEY_W-1){1'b0}}};

    logic [VERTEX_W-1:0] rd_v;
    logic [KEY_W-1:0]    rd_k;
    logic [SLOT_W-1:0]   parent_idx;
    logic [COUNT_W-1:0]  lchild, rchild;
    logic [COUNT_W-1:0]  last_idx;

    assign rd_v       = h_rdata[HEAP_W-1 -: VERTEX_W];
    assign rd_k       = h_rdata[KEY_W-1:0];
    assign parent_idx = SLOT_W'((idx_reg - 1'b1) >> 1);
    assign lchild     = {idx_reg, 1'b1};
    assign rchild     = COUNT_W'({idx_reg, 1'b1}) + 1'b1;
    assign last_idx   = count_reg - 1'b1;

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = (state_reg == S_DONE);
    assign m_out_vertex  = ov_reg;
    assign m_out_key     = ok_reg;
    assign m_status      = st_reg;
    assign m_is_empty    = (count_reg == '0);
    assign m_entry_total = count_reg;

    // memory port drive
    always_comb begin
        h_we = 1'b0; h_addr = idx_reg; h_wdata = {vtx_reg, key_reg};
        p_we = 1'b0; p_addr = vtx_reg; p_wdata = idx_reg;
        unique case (state_reg)
            S_POS_RD:     p_addr = vtx_reg;
            S_DEC_RD:     h_addr = p_rdata;
            S_UP_RD:      h_addr = parent_idx;
            // hold the parent address so its data is still there for the compare
            S_UP_WT:      h_addr = cidx_reg;
            S_UP_WR_P: begin
                // parent moves down into the hole
                h_we = 1'b1; h_addr = idx_reg; h_wdata = lft_reg;
                p_we = 1'b1; p_addr = lft_reg[HEAP_W-1 -: VERTEX_W]; p_wdata = idx_reg;
            end
            S_EX_RD:      h_addr = '0;
            S_EX_LAST_RD: h_addr = last_idx[SLOT_W-1:0];
            S_DN_L_RD:    h_addr = lchild[SLOT_W-1:0];
            S_DN_R_RD:    h_addr = rchild[SLOT_W-1:0];
            S_DN_WR_C: begin
                // child moves up into the hole
                h_we = 1'b1; h_addr = idx_reg; h_wdata = lft_reg;
                p_we = 1'b1; p_addr = lft_reg[HEAP_W-1 -: VERTEX_W]; p_wdata = idx_reg;
            end
            S_PLACE: begin
                h_we = 1'b1; h_addr = idx_reg;
                p_we = 1'b1; p_addr = vtx_reg; p_wdata = idx_reg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            present_reg <= '0;
        end else begin
            unique case (state_reg)
                S_IDLE: if (s_valid) begin
                    vtx_reg <= s_vertex;
                    key_reg <= s_key ^ BIAS;
                    ov_reg  <= '0;
                    ok_reg  <= '0;
                    st_reg  <= ST_OK;
                    unique case (s_opcode)
                        OP_INSERT: begin
                            if (count_reg >= COUNT_W'(LIMIT)) begin
                                st_reg <= ST_FULL; state_reg <= S_DONE;
                            end else if (present_reg[s_vertex]) begin
                                st_reg <= ST_BAD; state_reg <= S_DONE;
                            end else begin
                                idx_reg     <= count_reg[SLOT_W-1:0];
                                count_reg   <= count_reg + 1'b1;
                                present_reg[s_vertex] <= 1'b1;
                                state_reg   <= S_UP_RD;
                            end
                        end
                        OP_EXTRACT: begin
                            if (count_reg == '0) begin
                                st_reg <= ST_EMPTY; state_reg <= S_DONE;
                            end else begin
                                state_reg <= S_EX_RD;
                            end
                        end
                        OP_DECREASE: begin
                            if (!present_reg[s_vertex]) begin
                                st_reg <= ST_BAD; state_reg <= S_DONE;
                            end else begin
                                state_reg <= S_POS_RD;
                            end
                        end
                        default: begin
                            st_reg <= ST_BAD; state_reg <= S_DONE;
                        end
                    endcase
                end
                S_POS_RD: state_reg <= S_POS_WT;
                S_POS_WT: begin
                    idx_reg   <= p_rdata;
                    state_reg <= S_DEC_RD;
                end
                S_DEC_RD: state_reg <= S_DEC_WT;
                S_DEC_WT: state_reg <= S_DEC_CHK;
                S_DEC_CHK: begin
                    if (key_reg > rd_k) begin
                        st_reg <= ST_BAD; state_reg <= S_DONE;
                    end else begin
                        state_reg <= S_UP_RD;
                    end
                end
                S_UP_RD: begin
                    if (idx_reg == '0) begin
                        state_reg <= S_PLACE;
                    end else begin
                        cidx_reg  <= parent_idx;
                        state_reg <= S_UP_WT;
                    end
                end
                S_UP_WT: state_reg <= S_UP_CMP;
                S_UP_CMP: begin
                    lft_reg <= h_rdata;
                    if (rd_k <= key_reg) begin
                        state_reg <= S_PLACE;
                    end else begin
                        state_reg <= S_UP_WR_P;
                    end
                end
                S_UP_WR_P: begin
                    idx_reg   <= cidx_reg;
                    state_reg <= S_UP_RD;
                end
                S_EX_RD: state_reg <= S_EX_WT;
                S_EX_WT: begin
                    ov_reg <= rd_v;
                    ok_reg <= rd_k ^ BIAS;
                    present_reg[rd_v] <= 1'b0;
                    state_reg <= S_EX_LAST_RD;
                end
                S_EX_LAST_RD: state_reg <= S_EX_LAST_WT;
                S_EX_LAST_WT: begin
                    vtx_reg   <= rd_v;
                    key_reg   <= rd_k;
                    idx_reg   <= '0;
                    count_reg <= last_idx;
                    state_reg <= (last_idx == '0) ? S_DONE : S_DN_L_RD;
                end
                S_DN_L_RD: begin
                    if (lchild >= count_reg) begin
                        state_reg <= S_PLACE;
                    end else begin
                        state_reg <= S_DN_L_WT;
                    end
                end
                S_DN_L_WT: begin
                    lft_reg   <= h_rdata;
                    cidx_reg  <= lchild[SLOT_W-1:0];
                    state_reg <= S_DN_R_RD;
                end
                S_DN_R_RD: begin
                    state_reg <= (rchild >= count_reg) ? S_DN_CMP : S_DN_R_WT;
                end
                S_DN_R_WT: begin
                    // right child data; left wins ties
                    if (rd_k < lft_reg[KEY_W-1:0]) begin
                        lft_reg  <= h_rdata;
                        cidx_reg <= rchild[SLOT_W-1:0];
                    end
                    state_reg <= S_DN_CMP;
                end
                S_DN_CMP: begin
                    if (lft_reg[KEY_W-1:0] < key_reg) begin
                        state_reg <= S_DN_WR_C;
                    end else begin
                        state_reg <= S_PLACE;
                    end
                end
                S_DN_WR_C: begin
                    idx_reg   <= cidx_reg;
                    state_reg <= S_DN_L_RD;
                end
                S_PLACE: state_reg <= S_DONE;
                S_DONE: if (m_ready) begin
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

@@ verif/indexed_min_heap_test.sv @@
// Self-checking testbench for indexed_min_heap: insert, extract-min, decrease-key.
// Keeps its own heap and position map and compares every result transfer.
// Depends on imh_pkg and the indexed_min_heap RTL.
`timescale 1ns / 1ps

module indexed_min_heap_test;
    import imh_pkg::*;

    localparam int CYCLE_LIMIT = 2000000;
    localparam logic [1:0] OP_UNKNOWN = 2'd3;

    typedef struct packed {
        logic [VERTEX_W-1:0] vertex;
        logic [KEY_W-1:0]    key;
        logic [1:0]          status;
        logic                is_empty;
        logic [COUNT_W-1:0]  entry_total;
    } heap_result_t;

    logic                       aclk = 1'b0;
    logic                       aresetn = 1'b0;
    logic                       s_valid = 1'b0;
    logic                       s_ready;
    logic [1:0]                 s_opcode = OP_INSERT;
    logic [VERTEX_W-1:0]        s_vertex = '0;
    logic signed [KEY_W-1:0]    s_key = '0;
    logic                       m_valid;
    logic                       m_ready = 1'b0;
    logic [VERTEX_W-1:0]        m_out_vertex;
    logic signed [KEY_W-1:0]    m_out_key;
    logic [1:0]                 m_status;
    logic                       m_is_empty;
    logic [COUNT_W-1:0]         m_entry_total;

    indexed_min_heap DUT (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // predictor state
    logic [VERTEX_W-1:0]     heap_vertex [CAPACITY];
    logic signed [KEY_W-1:0] heap_key [CAPACITY];
    int                      slot_of [VERTICES];
    bit                      held [VERTICES];
    int                      heap_size = 0;

    heap_result_t pending_results[$];
    int errors = 0;
    int cycles = 0;
    bit drain_stall = 0;

    function automatic int gap_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic void place(int s, logic [VERTEX_W-1:0] v, logic signed [KEY_W-1:0] k);
        heap_vertex[s] = v;
        heap_key[s] = k;
        slot_of[v] = s;
    endfunction

    function automatic void swap_entries(int a, int b);
        logic [VERTEX_W-1:0] va;
        logic signed [KEY_W-1:0] ka;
        va = heap_vertex[a];
        ka = heap_key[a];
        place(a, heap_vertex[b], heap_key[b]);
        place(b, va, ka);
    endfunction

    function automatic void climb(int i);
        int p;
        while (i != 0) begin
            p = (i - 1) / 2;
            if (heap_key[p] <= heap_key[i]) break;
            swap_entries(i, p);
            i = p;
        end
    endfunction

    function automatic void sink(int i);
        int best, l, r;
        forever begin
            best = i;
            l = 2 * i + 1;
            r = 2 * i + 2;
            if (l < heap_size && heap_key[l] < heap_key[best]) best = l;
            if (r < heap_size && heap_key[r] < heap_key[best]) best = r;
            if (best == i) break;
            swap_entries(i, best);
            i = best;
        end
    endfunction

    function automatic heap_result_t heap_apply(logic [1:0] op, logic [VERTEX_W-1:0] v,
                                                logic signed [KEY_W-1:0] k);
        heap_result_t res;
        int s;
        res = '0;
        res.status = ST_OK;
        case (op)
            OP_INSERT: begin
                if (heap_size >= LIMIT) res.status = ST_FULL;
                else if (held[v]) res.status = ST_BAD;
                else begin
                    place(heap_size, v, k);
                    held[v] = 1;
                    heap_size++;
                    climb(heap_size - 1);
                end
            end
            OP_EXTRACT: begin
                if (heap_size == 0) res.status = ST_EMPTY;
                else begin
                    res.vertex = heap_vertex[0];
                    res.key = heap_key[0];
                    place(0, heap_vertex[heap_size - 1], heap_key[heap_size - 1]);
                    held[res.vertex] = 0;
                    heap_size--;
                    sink(0);
                end
            end
            OP_DECREASE: begin
                s = slot_of[v];
                if (!held[v] || s >= heap_size) res.status = ST_BAD;
                else if (k > heap_key[s]) res.status = ST_BAD;
                else begin
                    heap_key[s] = k;
                    climb(s);
                end
            end
            default: res.status = ST_BAD;
        endcase
        res.is_empty = (heap_size == 0);
        res.entry_total = heap_size[COUNT_W-1:0];
        return res;
    endfunction

    // valid stays high after a transfer until the next item or a gap begins
    task automatic send_command(logic [1:0] op, logic [VERTEX_W-1:0] v,
                                logic signed [KEY_W-1:0] k);
        int gap;
        gap = gap_length();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_opcode <= op;
        s_vertex <= v;
        s_key <= k;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        pending_results.push_back(heap_apply(op, v, k));
        @(negedge aclk);
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge aclk);
        repeat (100) @(negedge aclk);
    endtask

    // receiver: random stalls on m_ready
    initial begin
        int gap;
        forever begin
            @(negedge aclk);
            if (drain_stall || $urandom_range(0, 3) != 0) begin
                m_ready <= 1'b1;
            end else begin
                gap = gap_length();
                if (gap == 0) begin
                    m_ready <= 1'b1;
                end else begin
                    m_ready <= 1'b0;
                    repeat (gap) @(negedge aclk);
                    m_ready <= 1'b1;
                end
            end
        end
    end

    // result checker
    always @(posedge aclk) begin
        heap_result_t exp;
        cycles <= cycles + 1;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $error("result transfer with nothing expected");
                errors++;
            end else begin
                exp = pending_results.pop_front();
                if (m_out_vertex !== exp.vertex) begin
                    $error("out_vertex expected %0d actual %0d", exp.vertex, m_out_vertex);
                    errors++;
                end
                if (m_out_key !== exp.key) begin
                    $error("out_key expected %0d actual %0d",
                           $signed(exp.key), m_out_key);
                    errors++;
                end
                if (m_status !== exp.status) begin
                    $error("status expected %0d actual %0d", exp.status, m_status);
                    errors++;
                end
                if (m_is_empty !== exp.is_empty) begin
                    $error("is_empty expected %0d actual %0d", exp.is_empty, m_is_empty);
                    errors++;
                end
                if (m_entry_total !== exp.entry_total) begin
                    $error("entry_total expected %0d actual %0d",
                           exp.entry_total, m_entry_total);
                    errors++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (cycles > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic test_error_cases();
        send_command(OP_EXTRACT, 8'd0, 32'sd0);
        send_command(OP_DECREASE, 8'd5, 32'sd1);
        send_command(OP_UNKNOWN, 8'hFF, -32'sd1);
        send_command(OP_INSERT, 8'd5, 32'sd100);
        send_command(OP_INSERT, 8'd5, 32'sd7);
        send_command(OP_DECREASE, 8'd5, 32'sd101);
        send_command(OP_DECREASE, 8'd5, 32'sd100);
        send_command(OP_EXTRACT, 8'd0, 32'sd0);
        send_command(OP_EXTRACT, 8'd0, 32'sd0);
    endtask

    task automatic test_key_extremes();
        send_command(OP_INSERT, 8'hFF, 32'h7FFFFFFF);
        send_command(OP_INSERT, 8'h00, 32'h80000000);
        send_command(OP_INSERT, 8'hAA, 32'sd0);
        send_command(OP_INSERT, 8'h55, -32'sd1);
        send_command(OP_INSERT, 8'h01, 32'sd0);
        send_command(OP_DECREASE, 8'hFF, 32'h80000000);
        send_command(OP_DECREASE, 8'h00, 32'h80000000);
        repeat (6) send_command(OP_EXTRACT, 8'd0, 32'sd0);
    endtask

    // fill past capacity, then drain; ties on key exercise the child tie rule
    task automatic test_full_heap();
        for (int v = 0; v < VERTICES; v++)
            send_command(OP_INSERT, v[7:0], $signed($urandom_range(0, 15)));
        send_command(OP_INSERT, 8'd3, 32'sd0);
        for (int n = 0; n < 40; n++)
            send_command(OP_DECREASE, VERTEX_W'($urandom_range(0, 255)),
                         $signed($urandom_range(0, 15)) - 8);
        for (int n = 0; n < VERTICES; n++)
            send_command(OP_EXTRACT, 8'd0, 32'sd0);
    endtask

    task automatic test_random_traffic();
        int r;
        logic [VERTEX_W-1:0] v;
        logic signed [KEY_W-1:0] k;
        for (int n = 0; n < 1050; n++) begin
            if (n == 525) begin
                drain_stall = 1;
                wait_idle();
                drain_stall = 0;
            end
            r = $urandom_range(0, 99);
            v = (n < 525) ? VERTEX_W'($urandom_range(0, 31)) : VERTEX_W'($urandom);
            k = ($urandom_range(0, 3) == 0) ? $signed($urandom) : $signed($urandom_range(0, 200)) - 100;
            if (r < 45) begin
                send_command(OP_INSERT, v, k);
            end else if (r < 75) begin
                send_command(OP_EXTRACT, VERTEX_W'($urandom), $signed($urandom));
            end else if (r < 97) begin
                // mostly valid decreases on held vertices
                if (heap_size > 0 && $urandom_range(0, 4) != 0) begin
                    v = heap_vertex[$urandom_range(0, heap_size - 1)];
                    k = heap_key[slot_of[v]] - $signed($urandom_range(0, 50));
                    if (k > heap_key[slot_of[v]]) k = heap_key[slot_of[v]];
                end
                send_command(OP_DECREASE, v, k);
            end else begin
                send_command(OP_UNKNOWN, v, k);
            end
        end
    endtask

    initial begin
        for (int v = 0; v < VERTICES; v++) begin
            held[v] = 0;
            slot_of[v] = 0;
        end
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_error_cases();
        test_key_extremes();
        test_full_heap();
        test_random_traffic();
        wait_idle();
        if (errors == 0 && pending_results.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule

@@ filelist.f @@
hw/rtl/imh_pkg.sv
hw/rtl/imh_ram.sv
hw/rtl/indexed_min_heap.sv
verif/indexed_min_heap_test.sv
